// ===== src/wcsn_pkg.sv =====
// ----------------------------------------------------------------------------
// wcsn_pkg
// shared constants, types and the exp table for the clocked spiking neuron
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package wcsn_pkg;

  localparam int EXP_N           = 256;   // exp table intervals
  localparam int STEP_COUNT_WIDTH = 16;
  localparam int EXP_IW          = $clog2(EXP_N + 1);
  localparam int MUL_W           = 34;    // shared multiplier operand width
  localparam int PROD_W          = 2 * MUL_W;

  typedef logic signed [MUL_W-1:0]  mul_op_t;
  typedef logic signed [PROD_W-1:0] mul_prod_t;
  typedef logic [30:0]              exp_val_t;   // Q1.30
  typedef exp_val_t                 exp_tab_t [0:EXP_N];

  // configuration register indexes
  localparam logic [3:0] REG_LEAK      = 4'd0;
  localparam logic [3:0] REG_GAIN      = 4'd1;
  localparam logic [3:0] REG_INV_SIGMA = 4'd2;
  localparam logic [3:0] REG_DELAY     = 4'd3;
  localparam logic [3:0] REG_RESET_LVL = 4'd4;
  localparam logic [3:0] REG_THRESHOLD = 4'd5;
  localparam logic [3:0] REG_LOWER     = 4'd6;
  localparam logic [3:0] REG_REFRACT   = 4'd7;

  // series terms of exp(-32/N) in Q2.30
  localparam longint EXP_ONE = longint'(1) <<< 30;
  localparam longint EXP_X   = (longint'(1) <<< 35) / EXP_N;
  localparam longint EXP_T1  = (EXP_ONE * EXP_X) >>> 30;
  localparam longint EXP_T2  = ((EXP_T1 * EXP_X) >>> 30) / 2;
  localparam longint EXP_T3  = ((EXP_T2 * EXP_X) >>> 30) / 3;
  localparam longint EXP_T4  = ((EXP_T3 * EXP_X) >>> 30) / 4;
  localparam longint EXP_T5  = ((EXP_T4 * EXP_X) >>> 30) / 5;
  localparam longint EXP_T6  = ((EXP_T5 * EXP_X) >>> 30) / 6;
  localparam longint EXP_T7  = ((EXP_T6 * EXP_X) >>> 30) / 7;
  localparam longint EXP_T8  = ((EXP_T7 * EXP_X) >>> 30) / 8;
  localparam longint EXP_T9  = ((EXP_T8 * EXP_X) >>> 30) / 9;
  localparam longint EXP_T10 = ((EXP_T9 * EXP_X) >>> 30) / 10;
  localparam longint EXP_T11 = ((EXP_T10 * EXP_X) >>> 30) / 11;
  localparam longint EXP_T12 = ((EXP_T11 * EXP_X) >>> 30) / 12;
  localparam longint EXP_T13 = ((EXP_T12 * EXP_X) >>> 30) / 13;
  localparam longint EXP_T14 = ((EXP_T13 * EXP_X) >>> 30) / 14;
  localparam longint EXP_T15 = ((EXP_T14 * EXP_X) >>> 30) / 15;
  localparam longint EXP_T16 = ((EXP_T15 * EXP_X) >>> 30) / 16;
  localparam longint EXP_T17 = ((EXP_T16 * EXP_X) >>> 30) / 17;
  localparam longint EXP_T18 = ((EXP_T17 * EXP_X) >>> 30) / 18;
  localparam longint EXP_T19 = ((EXP_T18 * EXP_X) >>> 30) / 19;
  localparam longint EXP_T20 = ((EXP_T19 * EXP_X) >>> 30) / 20;
  localparam longint EXP_T21 = ((EXP_T20 * EXP_X) >>> 30) / 21;
  localparam longint EXP_T22 = ((EXP_T21 * EXP_X) >>> 30) / 22;
  localparam longint EXP_T23 = ((EXP_T22 * EXP_X) >>> 30) / 23;
  localparam longint EXP_T24 = ((EXP_T23 * EXP_X) >>> 30) / 24;
  localparam longint EXP_SERIES = EXP_ONE - EXP_T1 + EXP_T2 - EXP_T3 + EXP_T4
                                - EXP_T5 + EXP_T6 - EXP_T7 + EXP_T8 - EXP_T9
                                + EXP_T10 - EXP_T11 + EXP_T12 - EXP_T13
                                + EXP_T14 - EXP_T15 + EXP_T16 - EXP_T17
                                + EXP_T18 - EXP_T19 + EXP_T20 - EXP_T21
                                + EXP_T22 - EXP_T23 + EXP_T24;
  localparam longint EXP_RATIO = (EXP_SERIES < 0) ? longint'(0) : EXP_SERIES;

  // exp(-k*32/N) in Q1.30, each entry the previous one times the step ratio
  function automatic exp_tab_t exp_build();
    exp_tab_t          tab;
    longint unsigned   prv;
    longint unsigned   sum_u;
    sum_u  = longint'(EXP_RATIO);
    tab[0] = 31'h4000_0000;
    for (int k = 1; k <= EXP_N; k++) begin
      prv    = longint'(tab[k-1]);
      tab[k] = 31'((prv * sum_u + (longint'(1) << 29)) >> 30);
    end
    return tab;
  endfunction

  localparam exp_tab_t EXP_TAB = exp_build();

endpackage
`default_nettype wire

// ===== src/wcsn_mul.sv =====
// ----------------------------------------------------------------------------
// wcsn_mul
// shared signed multiplier with registered product
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module wcsn_mul (
  input  wire                 clk,
  input  wcsn_pkg::mul_op_t   op_a,
  input  wcsn_pkg::mul_op_t   op_b,
  output wcsn_pkg::mul_prod_t prod
);
  import wcsn_pkg::*;

  always_ff @(posedge clk) begin
    prod <= op_a * op_b;
  end

endmodule
`default_nettype wire

// ===== src/wavelet_clocked_spiking_neuron_step.sv =====
// ----------------------------------------------------------------------------
// wavelet_clocked_spiking_neuron_step
// clocked spiking neuron tick with mexican-hat wavelet integrator
// ----------------------------------------------------------------------------
//  channel | signals                                   | direction
//  in      | in_valid in_ready spike_weight input_current | beat into block
//  out     | out_valid out_ready spike membrane        | beat out of block
//  cfg     | cfg_valid cfg_ready cfg_index cfg_data    | register write
//
//  a refractory tick goes straight to close-out, a tick before the first clock
//  event skips the wavelet samples, and any other tick evaluates three wavelet
//  samples, all on one shared 34x34 multiplier used once per cycle
//  rst is synchronous: registers go to their defaults, all state to zero
//  in_ready is high only while idle; a finished tick waits in the output
//  register, and the next tick may start while it waits
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module wavelet_clocked_spiking_neuron_step (
  input  wire               clk,
  input  wire               rst,
  input  wire               in_valid,
  output logic              in_ready,
  input  wire signed [31:0] spike_weight,
  input  wire signed [31:0] input_current,
  output logic              out_valid,
  input  wire               out_ready,
  output logic              spike,
  output logic signed [31:0] membrane,
  input  wire               cfg_valid,
  output logic              cfg_ready,
  input  wire [3:0]         cfg_index,
  input  wire [31:0]        cfg_data
);
  import wcsn_pkg::*;

  localparam int STEP_W = STEP_COUNT_WIDTH;
  localparam int D_W    = ((STEP_W + 8 > 24) ? STEP_W + 8 : 24) + 2;
  localparam int POS_W  = 22 + EXP_IW;
  localparam logic [22:0] TT_MAX = 23'h40_0000;

  typedef enum logic [3:0] {
    S_IDLE, S_LEAK, S_GENV, S_DRV, S_ENV, S_WSTART,
    W_SQ, W_LO, W_HI, W_TT, W_EXP, W_MULW, W_ACC,
    S_INC, S_WADD, S_FIN
  } st_t;

  st_t st;

  // configuration
  logic [16:0]        leak_factor;
  logic [30:0]        drive_gain;
  logic [23:0]        inv_sigma_sq;
  logic [23:0]        delay_offset;
  logic signed [31:0] reset_level;
  logic signed [31:0] threshold;
  logic signed [31:0] lower_bound;
  logic [15:0]        refractory_steps;

  // neuron state
  logic signed [31:0] membrane_value;
  logic signed [31:0] wavelet_sum;
  logic signed [31:0] latched_sum;
  logic [16:0]        envelope;
  logic signed [31:0] held_current;
  logic [STEP_W-1:0]  steps;
  logic               clock_seen;
  logic [15:0]        refr;

  // per-tick working registers
  logic signed [31:0] cur_r;
  logic signed [31:0] vm0;
  logic signed [32:0] u_acc;
  logic signed [42:0] u_r;
  logic [1:0]         wj;
  logic [23:0]        p_hi;
  logic [23:0]        tlo;
  logic [22:0]        tt_r;
  exp_val_t           tab_i_r;
  logic               zero_r;
  logic signed [27:0] s_acc;

  mul_op_t   mul_a;
  mul_op_t   mul_b;
  mul_prod_t prod;

  wcsn_mul u_mul (.clk(clk), .op_a(mul_a), .op_b(mul_b), .prod(prod));

  // combinational helpers
  logic [16:0]         leak_c;
  logic                clk_ev;
  logic signed [31:0]  ws_abs;
  logic [30:0]         lat;
  logic signed [D_W-1:0] d_j;
  logic [D_W-1:0]      mag;
  logic [48:0]         tt_sum;
  logic [21:0]         a_e;
  logic [POS_W-1:0]    pos;
  logic [POS_W-22:0]   i_full;
  logic                e_zero;
  logic [EXP_IW-1:0]   idx;
  exp_val_t            tab_i;
  exp_val_t            tab_n;
  exp_val_t            diff;
  exp_val_t            v;
  logic [31:0]         v_rnd;
  logic [16:0]         e_w;
  logic signed [23:0]  one_m_tt;
  logic signed [27:0]  w_s;
  logic signed [52:0]  ws_new;
  logic [47:0]         drv_raw;
  logic [40:0]         drive;
  logic signed [31:0]  u_sat;
  logic signed [31:0]  mem_f;
  logic signed [31:0]  mem_out;
  logic                spk;
  logic                out_free;

  assign cfg_ready = 1'b1;
  assign in_ready  = (st == S_IDLE);
  assign out_free  = !out_valid || out_ready;

  assign leak_c = (leak_factor > 17'h10000) ? 17'h10000 : leak_factor;
  assign clk_ev = spike_weight > 32'sd6553;
  assign ws_abs = (wavelet_sum == 32'sh8000_0000) ? 32'sh7fff_ffff :
                  (wavelet_sum < 0) ? -wavelet_sum : wavelet_sum;
  assign lat    = latched_sum[31] ? 31'd0 : latched_sum[30:0];

  // delay of the current sample in q.8 steps: d, d+0.5, d+1
  assign d_j = $signed({{(D_W-STEP_W-8){1'b0}}, steps, 8'b0})
             - $signed({{(D_W-24){1'b0}}, delay_offset})
             + $signed({{(D_W-9){1'b0}}, wj, 7'b0});
  assign mag = d_j[D_W-1] ? D_W'(-d_j) : D_W'(d_j);

  assign tt_sum = prod[48:0] + {25'b0, tlo};

  // table lookup with linear interpolation
  assign a_e    = tt_r[22:1];
  assign pos    = POS_W'(a_e) * POS_W'(EXP_N);
  assign i_full = pos[POS_W-1:21];
  assign e_zero = a_e[21] || (i_full >= (POS_W-21)'(EXP_N));
  assign idx    = e_zero ? '0 : i_full[EXP_IW-1:0];
  assign tab_i  = EXP_TAB[idx];
  assign tab_n  = EXP_TAB[idx + EXP_IW'(1)];
  assign diff   = (tab_i >= tab_n) ? tab_i - tab_n : '0;

  assign v        = tab_i_r - prod[51:21];
  assign v_rnd    = ({1'b0, v} + 32'h2000) >> 14;
  assign e_w      = zero_r ? 17'd0 : v_rnd[16:0];
  assign one_m_tt = 24'sd65536 - $signed({1'b0, tt_r});
  assign w_s      = prod[43:16];

  assign ws_new  = 53'(wavelet_sum) + 53'($signed(prod[67:16]));
  assign drv_raw = prod[63:16];
  assign drive   = (drv_raw > 48'h100_0000_0000) ? 41'h100_0000_0000 : drv_raw[40:0];

  // membrane close-out
  assign u_sat = (u_r > 43'sh7fff_ffff) ? 32'sh7fff_ffff :
                 (u_r < -43'sh8000_0000) ? 32'sh8000_0000 : u_r[31:0];
  assign mem_f = (refr != 16'd0) ? membrane_value :
                 (u_sat < lower_bound) ? lower_bound : u_sat;
  assign spk     = (vm0 < threshold) && (mem_f >= threshold);
  assign mem_out = spk ? reset_level : mem_f;

  // operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (st)
      S_LEAK: begin
        mul_a = MUL_W'(leak_c);
        mul_b = MUL_W'(membrane_value);
      end
      S_GENV: begin
        mul_a = MUL_W'(drive_gain);
        mul_b = MUL_W'(envelope);
      end
      S_DRV: begin
        mul_a = MUL_W'(prod[48:16]);
        mul_b = MUL_W'(lat);
      end
      S_ENV: begin
        mul_a = MUL_W'(envelope);
        mul_b = MUL_W'(leak_c);
      end
      W_SQ: begin
        mul_a = MUL_W'(mag[23:0]);
        mul_b = MUL_W'(mag[23:0]);
      end
      W_LO: begin
        mul_a = MUL_W'(prod[23:0]);
        mul_b = MUL_W'(inv_sigma_sq);
      end
      W_HI: begin
        mul_a = MUL_W'(p_hi);
        mul_b = MUL_W'(inv_sigma_sq);
      end
      W_EXP: begin
        mul_a = MUL_W'(diff);
        mul_b = MUL_W'(pos[20:0]);
      end
      W_MULW: begin
        mul_a = MUL_W'(one_m_tt);
        mul_b = MUL_W'(e_w);
      end
      S_INC: begin
        mul_a = MUL_W'(s_acc);
        mul_b = MUL_W'(held_current);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st               <= S_IDLE;
      leak_factor      <= 17'd63350;
      drive_gain       <= 31'd65536;
      inv_sigma_sq     <= 24'd186;
      delay_offset     <= 24'd0;
      reset_level      <= -32'sd655360;
      threshold        <= -32'sd65536;
      lower_bound      <= 32'sh8000_0000;
      refractory_steps <= 16'd20;
      membrane_value   <= '0;
      wavelet_sum      <= '0;
      latched_sum      <= '0;
      envelope         <= '0;
      held_current     <= '0;
      steps            <= '0;
      clock_seen       <= 1'b0;
      refr             <= '0;
      out_valid        <= 1'b0;
      spike            <= 1'b0;
      membrane         <= '0;
      wj               <= '0;
    end else begin
      // close-out loads the next beat itself
      if (out_valid && out_ready && st != S_FIN) out_valid <= 1'b0;

      if (cfg_valid) begin
        case (cfg_index)
          REG_LEAK:      leak_factor      <= cfg_data[16:0];
          REG_GAIN:      drive_gain       <= cfg_data[30:0];
          REG_INV_SIGMA: inv_sigma_sq     <= cfg_data[23:0];
          REG_DELAY:     delay_offset     <= cfg_data[23:0];
          REG_RESET_LVL: reset_level      <= cfg_data;
          REG_THRESHOLD: threshold        <= cfg_data;
          REG_LOWER:     lower_bound      <= cfg_data;
          REG_REFRACT:   refractory_steps <= cfg_data[15:0];
          default: ;
        endcase
      end

      case (st)
        S_IDLE: begin
          if (in_valid) begin
            cur_r <= input_current;
            // clock event: latch integral, restart membrane and envelope
            if (clk_ev) begin
              latched_sum    <= ws_abs;
              wavelet_sum    <= '0;
              membrane_value <= reset_level;
              envelope       <= 17'h10000;
              steps          <= '0;
              clock_seen     <= 1'b1;
              vm0            <= reset_level;
            end else begin
              vm0 <= membrane_value;
            end
            st <= (refr == 16'd0) ? S_LEAK : S_FIN;
          end
        end
        S_LEAK: st <= S_GENV;
        S_GENV: begin
          u_acc <= prod[48:16];
          st    <= S_DRV;
        end
        S_DRV: st <= S_ENV;
        S_ENV: begin
          u_r <= 43'(u_acc) + $signed({2'b0, drive});
          st  <= S_WSTART;
        end
        S_WSTART: begin
          envelope <= prod[32:16];
          wj       <= '0;
          s_acc    <= '0;
          st       <= clock_seen ? W_SQ : S_FIN;
        end
        W_SQ: begin
          // zero inverse sigma or far delay skip the squaring
          if (inv_sigma_sq == 24'd0) begin
            tt_r <= '0;
            st   <= W_EXP;
          end else if (mag[D_W-1:24] != '0) begin
            tt_r <= TT_MAX;
            st   <= W_EXP;
          end else begin
            st <= W_LO;
          end
        end
        W_LO: begin
          p_hi <= prod[47:24];
          st   <= W_HI;
        end
        W_HI: begin
          tlo <= prod[47:24];
          st  <= W_TT;
        end
        W_TT: begin
          tt_r <= (tt_sum > 49'(TT_MAX)) ? TT_MAX : tt_sum[22:0];
          st   <= W_EXP;
        end
        W_EXP: begin
          tab_i_r <= tab_i;
          zero_r  <= e_zero;
          st      <= W_MULW;
        end
        W_MULW: st <= W_ACC;
        W_ACC: begin
          // simpson weights 1, 4, 1
          s_acc <= s_acc + ((wj == 2'd1) ? (w_s <<< 2) : w_s);
          if (wj == 2'd2) begin
            st <= S_INC;
          end else begin
            wj <= wj + 2'd1;
            st <= W_SQ;
          end
        end
        S_INC: st <= S_WADD;
        S_WADD: begin
          wavelet_sum <= (ws_new > 53'sh7fff_ffff) ? 32'sh7fff_ffff :
                         (ws_new < -53'sh8000_0000) ? 32'sh8000_0000 : ws_new[31:0];
          st <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            if (refr != 16'd0) refr <= refr - 16'd1;
            membrane_value <= mem_out;
            if (spk) begin
              refr        <= refractory_steps;
              envelope    <= '0;
              latched_sum <= '0;
            end
            held_current <= cur_r;
            if (steps != '1) steps <= steps + STEP_W'(1);
            out_valid <= 1'b1;
            spike     <= spk;
            membrane  <= mem_out;
            st        <= S_IDLE;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  // busy after every accepted beat
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted twice in a row");

  // results only come out of the close-out step
  a_out_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(st == S_FIN))
    else $error("output raised outside close-out");

  // a spike resets the membrane and loads the refractory count
  a_spike_reset: assert property (@(posedge clk) disable iff (rst)
    out_valid && spike |-> membrane == reset_level && refr == refractory_steps)
    else $error("spike without reset");

endmodule
`default_nettype wire
